FILE: hdl/pid_pkg.sv
package pid_pkg;

	localparam int DATA_W  = 16;
	localparam int ERR_W   = 17;
	localparam int LIMIT_W = 15;
	localparam int ADDR_W  = 5;
	localparam int PDATA_W = 32;

	// Register map, one 32-bit word per register.
	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_TARGET    = 3'd4,
		REG_OUT_LOW   = 3'd5,
		REG_OUT_HIGH  = 3'd6,
		REG_INT_LIMIT = 3'd7
	} pid_reg_t;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic signed [DATA_W-1:0] OUT_LOW_RESET  = 16'sh8000;
	localparam logic signed [DATA_W-1:0] OUT_HIGH_RESET = 16'sh7FFF;
	localparam logic [LIMIT_W-1:0]       INT_LIMIT_RESET = 15'd16383;

	typedef struct packed {
		logic                      mode;
		logic signed [DATA_W-1:0]  gain_p;
		logic signed [DATA_W-1:0]  gain_i;
		logic signed [DATA_W-1:0]  gain_d;
		logic signed [DATA_W-1:0]  target;
		logic signed [DATA_W-1:0]  out_low;
		logic signed [DATA_W-1:0]  out_high;
		logic [LIMIT_W-1:0]        integral_limit;
	} pid_cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] integ;
		logic signed [ERR_W-1:0]  err1;
		logic signed [ERR_W-1:0]  err2;
		logic signed [DATA_W-1:0] held;
	} pid_state_t;

endpackage

FILE: hdl/pid_if.sv
interface pid_sample_if import pid_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [DATA_W-1:0] measurement;

	modport source (output valid, output kind, output measurement, input ready);
	modport sink (input valid, input kind, input measurement, output ready);
endinterface

interface pid_drive_if import pid_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

FILE: hdl/pid_controller_positional_incremental.sv
// Fixed-point PID regulator with a positional and an incremental form.
// The sample channel carries one item per transfer: kind selects a
// measurement sample or a clear of all loop state. The result channel
// returns exactly one drive value per accepted item, in order.
// Gains, setpoint, output range, integral limit and mode are set through
// the APB port, one 32-bit word per register. The user must see that they
// are written only while no item is in flight; the block does not enforce it.
// An item is captured in the input register, processed by a single pass
// of multiply, add and clamp logic, and its drive is then registered and
// presented from the result register.
// Throughput is one item per cycle while the receiver keeps ready high;
// the loop state (integral, two past errors, held output) is updated at
// the same edge as the result register, so the following item already sees it.
// If the receiver stalls, the result register holds its value and the
// input register fills behind it; ready drops only when both are full.
// Reset clears the loop state, both pipeline valids and the registers
// to their defaults (full output range, integral limit 16383).
module pid_controller_positional_incremental import pid_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	pid_sample_if.sink          sample,
	pid_drive_if.source         result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	pid_cfg_t                 cfg_q;
	pid_state_t               state_q;
	pid_state_t               state_next;
	logic                     valid_s1;
	logic                     kind_s1;
	logic signed [DATA_W-1:0] meas_s1;
	logic                     valid_s2;
	logic signed [DATA_W-1:0] drive_s2;
	logic signed [DATA_W-1:0] drive_calc;
	logic                     advance;
	logic                     cfg_wr;
	pid_reg_t                 reg_sel;

	// ---------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready
	// is tied high so there are no wait states.
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = pid_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_POSITIONAL;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.target         <= '0;
			cfg_q.out_low        <= OUT_LOW_RESET;
			cfg_q.out_high       <= OUT_HIGH_RESET;
			cfg_q.integral_limit <= INT_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_MODE:      cfg_q.mode           <= pwdata[0];
				REG_GAIN_P:    cfg_q.gain_p         <= pwdata[DATA_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i         <= pwdata[DATA_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d         <= pwdata[DATA_W-1:0];
				REG_TARGET:    cfg_q.target         <= pwdata[DATA_W-1:0];
				REG_OUT_LOW:   cfg_q.out_low        <= pwdata[DATA_W-1:0];
				REG_OUT_HIGH:  cfg_q.out_high       <= pwdata[DATA_W-1:0];
				REG_INT_LIMIT: cfg_q.integral_limit <= pwdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read data is the raw register bits, zero-extended to the bus.
	always_comb begin
		case (reg_sel)
			REG_MODE:      prdata = {{(PDATA_W-1){1'b0}}, cfg_q.mode};
			REG_GAIN_P:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.gain_p};
			REG_GAIN_I:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.gain_i};
			REG_GAIN_D:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.gain_d};
			REG_TARGET:    prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.target};
			REG_OUT_LOW:   prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.out_low};
			REG_OUT_HIGH:  prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg_q.out_high};
			REG_INT_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_q.integral_limit};
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline control. The item in the input register moves into the
	// result register whenever that register is empty or being drained
	// in the same cycle; the loop state advances with it.
	// ---------------------------------------------------------------
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.drive = drive_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			kind_s1 <= sample.kind;
			meas_s1 <= sample.measurement;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_calc;
		end
	end

	// Loop state: integral, last two errors and the held output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	pid_datapath #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_datapath (
		.cfg         (cfg_q),
		.state       (state_q),
		.kind        (kind_s1),
		.measurement (meas_s1),
		.state_next  (state_next),
		.drive       (drive_calc)
	);

	// ---------------------------------------------------------------
	// Checks on the pipeline and the loop state.
	// ---------------------------------------------------------------

	// The held output always mirrors the drive waiting in the result register.
	a_held_matches_drive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (state_q.held == drive_s2))
		else $error("held output differs from presented drive");

	// A clear item leaves all loop state zero and returns zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && kind_s1 == KIND_CLEAR) |=>
			(state_q == '0) && (drive_s2 == '0) && valid_s2)
		else $error("clear item did not zero the loop state");

	// Loop state only moves when an item leaves the input register.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("loop state changed without an item advancing");

endmodule

FILE: hdl/pid_datapath.sv
module pid_datapath import pid_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  pid_cfg_t                 cfg,
	input  pid_state_t               state,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] measurement,
	output pid_state_t               state_next,
	output logic signed [DATA_W-1:0] drive
);

	logic signed [ERR_W-1:0] err;
	logic signed [17:0]      err_x;
	logic signed [17:0]      d1;
	logic signed [18:0]      d2;
	logic signed [17:0]      isum;
	logic signed [17:0]      lim;
	logic signed [17:0]      integ_new;
	logic signed [17:0]      op_p;
	logic signed [17:0]      op_i;
	logic signed [18:0]      op_d;
	logic signed [33:0]      prod_p;
	logic signed [33:0]      prod_i;
	logic signed [34:0]      prod_d;
	logic signed [37:0]      acc;
	logic signed [37:0]      acc_sh;
	logic signed [38:0]      total;
	logic signed [38:0]      clamped;

	assign err   = {cfg.target[DATA_W-1], cfg.target} - {measurement[DATA_W-1], measurement};
	assign err_x = {err[ERR_W-1], err};
	assign d1    = err_x - {state.err1[ERR_W-1], state.err1};
	assign d2    = {err[ERR_W-1], err[ERR_W-1], err}
	             - {state.err1[ERR_W-1], state.err1, 1'b0}
	             + {state.err2[ERR_W-1], state.err2[ERR_W-1], state.err2};

	// Integral accumulates and saturates symmetrically at the limit.
	assign isum = {{2{state.integ[DATA_W-1]}}, state.integ} + err_x;
	assign lim  = {3'b000, cfg.integral_limit};

	always_comb begin
		integ_new = isum;
		if (isum > lim) begin
			integ_new = lim;
		end
		if (isum < -lim) begin
			integ_new = -lim;
		end
	end

	// The three multipliers are shared by both forms; only the operands change.
	always_comb begin
		if (cfg.mode == MODE_INCREMENTAL) begin
			op_p = d1;
			op_i = err_x;
			op_d = d2;
		end else begin
			op_p = err_x;
			op_i = integ_new;
			op_d = {d1[17], d1};
		end
	end

	assign prod_p = cfg.gain_p * op_p;
	assign prod_i = cfg.gain_i * op_i;
	assign prod_d = cfg.gain_d * op_d;
	assign acc    = 38'(prod_p) + 38'(prod_i) + 38'(prod_d);
	assign acc_sh = acc >>> GAIN_FRAC_BITS;
	assign total  = (cfg.mode == MODE_INCREMENTAL) ? (39'(state.held) + 39'(acc_sh))
	                                               : 39'(acc_sh);

	// Upper bound first, then lower, so an inverted range yields out_low.
	always_comb begin
		clamped = total;
		if (clamped > 39'(cfg.out_high)) begin
			clamped = 39'(cfg.out_high);
		end
		if (clamped < 39'(cfg.out_low)) begin
			clamped = 39'(cfg.out_low);
		end
	end

	always_comb begin
		state_next = state;
		drive      = clamped[DATA_W-1:0];
		if (kind == KIND_CLEAR) begin
			state_next = '0;
			drive      = '0;
		end else begin
			state_next.err1 = err;
			state_next.held = clamped[DATA_W-1:0];
			if (cfg.mode == MODE_INCREMENTAL) begin
				state_next.err2 = state.err1;
			end else begin
				state_next.integ = integ_new[DATA_W-1:0];
			end
		end
	end

endmodule
